/* hdl/cfp_pkg.sv */
// shared widths, state codes and arithmetic sizes for the coulomb field unit
// no dependencies
package cfp_pkg;

    localparam int X_W      = 33;   // offset between two q16.16 positions
    localparam int A_W      = 35;   // nine times the charge magnitude
    localparam int D2_W     = 66;   // squared distance
    localparam int D2_HALF  = 33;   // split point of the squared distance
    localparam int R_W      = 35;   // rounded root of the squared distance
    localparam int P_W      = 68;   // charge magnitude times an offset
    localparam int DR_W     = 101;  // squared distance times root
    localparam int DEN_W    = 112;  // widest divisor
    localparam int NUM_W    = 128;  // widest dividend
    localparam int QUO_W    = 63;   // quotient bits kept below the clamp
    localparam int DIVC_W   = 6;
    localparam int SQ_W     = 70;   // radicand, padded to an even width
    localparam int SQREM_W  = 38;
    localparam int SQ_STEPS = 35;
    localparam int SQC_W    = 6;
    localparam int POT_SHIFT   = 40;
    localparam int FIELD_SHIFT = 56;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_SQ1,
        ST_SQ2,
        ST_SQRT,
        ST_ROUND,
        ST_MULA,
        ST_MULB,
        ST_MULC,
        ST_MULD,
        ST_MULE,
        ST_DIVGO,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } state_t;

endpackage

/* hdl/cfp_div.sv */
// bit-serial restoring divider with clamp detection, one quotient bit per cycle
// depends on cfp_pkg
module cfp_div
    import cfp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [QUO_W-1:0] quo,
    output logic             sat
);

    logic [DIVC_W-1:0] cnt_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QUO_W-1:0]  low_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              sat_reg;
    logic [DEN_W:0]    trial;
    logic              ge;
    logic [DEN_W:0]    diff;
    logic              clamp;

    // quotient reaches 2^63 exactly when the top bits already reach the divisor
    assign clamp = {{(DEN_W-(NUM_W-QUO_W)){1'b0}}, num[NUM_W-1:QUO_W]} >= den;
    assign trial = {rem_reg, low_reg[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= clamp ? '0 : DIVC_W'(QUO_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sat_reg <= clamp;
            rem_reg <= DEN_W'(num[NUM_W-1:QUO_W]);
            den_reg <= den;
            low_reg <= num[QUO_W-1:0];
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign busy = cnt_reg != '0;
    assign quo  = quo_reg;
    assign sat  = sat_reg;

endmodule

/* hdl/coulomb_field_potential_unit.sv */
// top level of the coulomb field and potential unit: charge table, sequencer, datapath
// depends on cfp_pkg and cfp_div
//
// The unit keeps a table of MAX_CHARGES point charges in a single-port synchronous
// memory (position, charge and ignored flag per entry, plus an active bit per entry in
// flip-flops that reset clears). A write beat (action 0) stores one entry; writes to an
// index at or beyond MAX_CHARGES are dropped. A query beat (action 1) walks the table
// in index order and returns one result beat with the summed field x, field y (screen
// axis, entry y minus point y) and potential in signed Q40.24, with k = 9e9 and charges
// in picocoulombs. Entries at the query point are left out. Each term and each running
// sum saturates and raises saturated. The walk visits every index and loads each stored
// entry; each entry that contributes runs a 35-step square root and then three 63-step
// dividers side by side, and the divide is cut short when all three of its terms clamp.
// The input side stalls while a query is being worked; a finished result sits in an
// output register, so the next beat can be taken while it waits.
module coulomb_field_potential_unit
    import cfp_pkg::*;
#(
    parameter int MAX_CHARGES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [3:0]         entry_index,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] charge_pc,
    input  logic               ignored,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] field_x,
    output logic signed [63:0] field_y,
    output logic signed [63:0] potential,
    output logic               saturated
);

    localparam int IDX_W = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
    localparam int MEM_W = 97;   // ignored flag, charge, y, x

    // charge table
    logic [MEM_W-1:0]       mem [MAX_CHARGES];
    logic [MEM_W-1:0]       rd_data_reg;
    logic [MAX_CHARGES-1:0] active_reg;

    state_t state_reg, state_next;

    logic             in_fire;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             last_idx;
    logic             div_start;
    logic             out_load;

    logic [IDX_W-1:0] idx_reg;
    logic [31:0]      qx_reg, qy_reg;

    // per-entry working registers
    logic [X_W-1:0]    ax_reg, ay_reg;
    logic              xneg_reg, yneg_reg, qneg_reg;
    logic [A_W-1:0]    a_reg;
    logic [D2_W-1:0]   d2_reg;
    logic [SQ_W-1:0]   sqv_reg;
    logic [SQREM_W-1:0] sqrem_reg;
    logic [R_W-1:0]    root_reg;
    logic [SQC_W-1:0]  sqc_reg;
    logic [P_W-1:0]    pa_reg, pb_reg;
    logic [DR_W-1:0]   dr_reg;
    logic [DEN_W-1:0]  denf_reg;

    // running sums
    logic signed [63:0] pot_reg, fx_reg, fy_reg;
    logic               sat_reg;

    // output register
    logic               out_valid_reg;
    logic signed [63:0] out_fx_reg, out_fy_reg, out_pot_reg;
    logic               out_sat_reg;

    // decode of the entry just read
    logic [31:0]    e_x, e_y, e_q;
    logic           e_skip;
    logic [X_W-1:0] x_off, y_off;
    logic [31:0]    q_mag;
    logic           at_point;

    // square root step
    logic [SQREM_W-1:0] sq_rem2, sq_trial;
    logic               sq_ge;

    // dividers
    logic [NUM_W-1:0] num_p, num_x, num_y;
    logic [DEN_W-1:0] den_p;
    logic [2:0]       dv_busy;
    logic [QUO_W-1:0] quo_p, quo_x, quo_y;
    logic             dsat_p, dsat_x, dsat_y;

    // accumulation
    logic signed [63:0] t_p, t_x, t_y;
    logic signed [63:0] s_p, s_x, s_y;
    logic               o_p, o_x, o_y;

    function automatic logic signed [63:0] make_term(input logic [QUO_W-1:0] q,
                                                     input logic clamp,
                                                     input logic neg);
        logic [63:0] mag;
        mag = clamp ? {1'b0, {QUO_W{1'b1}}} : {1'b0, q};
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] acc,
                                                   input logic signed [63:0] t,
                                                   output logic ovf);
        logic [64:0] s;
        s   = {acc[63], acc} + {t[63], t};
        ovf = s[64] != s[63];
        if (ovf)
        begin
            return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end
        return $signed(s[63:0]);
    endfunction

    assign in_fire  = in_valid && !in_stall;
    assign wr_en    = in_fire && (action == ACT_WRITE) && (32'(entry_index) < MAX_CHARGES);
    assign wr_addr  = IDX_W'(entry_index);
    assign last_idx = idx_reg == IDX_W'(MAX_CHARGES - 1);

    // table memory, no reset; a write and a query walk never overlap
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {ignored, charge_pc, pos_y, pos_x};
        end
        if (state_reg == ST_SCAN)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (wr_en)
        begin
            active_reg[wr_addr] <= 1'b1;
        end
    end

    assign e_x    = rd_data_reg[31:0];
    assign e_y    = rd_data_reg[63:32];
    assign e_q    = rd_data_reg[95:64];
    assign e_skip = rd_data_reg[96];

    assign x_off    = {qx_reg[31], qx_reg} - {e_x[31], e_x};
    assign y_off    = {e_y[31], e_y} - {qy_reg[31], qy_reg};
    assign at_point = (x_off == '0) && (y_off == '0);
    assign q_mag    = e_q[31] ? -e_q : e_q;

    assign sq_rem2  = {sqrem_reg[SQREM_W-3:0], sqv_reg[SQ_W-1:SQ_W-2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = sq_rem2 >= sq_trial;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && action == ACT_QUERY)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (active_reg[idx_reg])
                begin
                    state_next = ST_LOAD;
                end
                else if (last_idx)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LOAD:
            begin
                if (!e_skip && !at_point)
                begin
                    state_next = ST_SQ1;
                end
                else if (last_idx)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SQ1:   state_next = ST_SQ2;
            ST_SQ2:   state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (sqc_reg == SQC_W'(1))
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: state_next = ST_MULA;
            ST_MULA:  state_next = ST_MULB;
            ST_MULB:  state_next = ST_MULC;
            ST_MULC:  state_next = ST_MULD;
            ST_MULD:  state_next = ST_MULE;
            ST_MULE:  state_next = ST_DIVGO;
            ST_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (dv_busy == '0)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:   state_next = last_idx ? ST_DONE : ST_SCAN;
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // table walk index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (state_reg == ST_IDLE)
        begin
            idx_reg <= '0;
        end
        else if (!last_idx && ((state_reg == ST_SCAN && !active_reg[idx_reg]) ||
                               (state_reg == ST_LOAD && (e_skip || at_point)) ||
                               state_reg == ST_ACC))
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // per-entry datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                qx_reg <= pos_x;
                qy_reg <= pos_y;
            end
            ST_LOAD:
            begin
                ax_reg   <= x_off[X_W-1] ? -x_off : x_off;
                ay_reg   <= y_off[X_W-1] ? -y_off : y_off;
                xneg_reg <= x_off[X_W-1];
                yneg_reg <= y_off[X_W-1];
                qneg_reg <= e_q[31];
                a_reg    <= (A_W'(q_mag) << 3) + A_W'(q_mag);
            end
            ST_SQ1:
            begin
                d2_reg <= D2_W'(ax_reg * ax_reg);
            end
            ST_SQ2:
            begin
                // radicand loaded straight from the finished sum
                d2_reg    <= d2_reg + D2_W'(ay_reg * ay_reg);
                sqv_reg   <= SQ_W'(d2_reg + D2_W'(ay_reg * ay_reg));
                sqrem_reg <= '0;
                root_reg  <= '0;
                sqc_reg   <= SQC_W'(SQ_STEPS);
            end
            ST_SQRT:
            begin
                sqv_reg   <= {sqv_reg[SQ_W-3:0], 2'b00};
                sqrem_reg <= sq_ge ? sq_rem2 - sq_trial : sq_rem2;
                root_reg  <= {root_reg[R_W-2:0], sq_ge};
                sqc_reg   <= sqc_reg - 1'b1;
            end
            ST_ROUND:
            begin
                // round to nearest, ties up
                if (sqrem_reg > SQREM_W'(root_reg))
                begin
                    root_reg <= root_reg + 1'b1;
                end
            end
            ST_MULA: pa_reg <= P_W'(a_reg * ax_reg);
            ST_MULB: pb_reg <= P_W'(a_reg * ay_reg);
            ST_MULC: dr_reg <= DR_W'(d2_reg[D2_HALF-1:0] * root_reg);
            ST_MULD: dr_reg <= dr_reg + (DR_W'(d2_reg[D2_W-1:D2_HALF] * root_reg) << D2_HALF);
            ST_MULE:
            begin
                denf_reg <= (DEN_W'(dr_reg) << 10) - (DEN_W'(dr_reg) << 4)
                            - (DEN_W'(dr_reg) << 3);
            end
            default:
            begin
            end
        endcase
    end

    // numerators and divisors of the three terms
    assign num_p = NUM_W'(a_reg) << POT_SHIFT;
    assign num_x = NUM_W'(pa_reg) << FIELD_SHIFT;
    assign num_y = NUM_W'(pb_reg) << FIELD_SHIFT;
    assign den_p = (DEN_W'(root_reg) << 10) - (DEN_W'(root_reg) << 4)
                   - (DEN_W'(root_reg) << 3);

    cfp_div u_div_p (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_p),
        .den   (den_p),
        .busy  (dv_busy[0]),
        .quo   (quo_p),
        .sat   (dsat_p)
    );

    cfp_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_x),
        .den   (denf_reg),
        .busy  (dv_busy[1]),
        .quo   (quo_x),
        .sat   (dsat_x)
    );

    cfp_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_y),
        .den   (denf_reg),
        .busy  (dv_busy[2]),
        .quo   (quo_y),
        .sat   (dsat_y)
    );

    // signed terms and saturating sums
    always_comb
    begin
        t_p = make_term(quo_p, dsat_p, qneg_reg);
        t_x = make_term(quo_x, dsat_x, qneg_reg ^ xneg_reg);
        t_y = make_term(quo_y, dsat_y, qneg_reg ^ yneg_reg);
        s_p = sat_add(pot_reg, t_p, o_p);
        s_x = sat_add(fx_reg, t_x, o_x);
        s_y = sat_add(fy_reg, t_y, o_y);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            pot_reg <= '0;
            fx_reg  <= '0;
            fy_reg  <= '0;
            sat_reg <= 1'b0;
        end
        else if (state_reg == ST_ACC)
        begin
            pot_reg <= s_p;
            fx_reg  <= s_x;
            fy_reg  <= s_y;
            sat_reg <= sat_reg | dsat_p | dsat_x | dsat_y | o_p | o_x | o_y;
        end
    end

    // result register, holds while the far side stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_fx_reg  <= fx_reg;
            out_fy_reg  <= fy_reg;
            out_pot_reg <= pot_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign field_x   = out_fx_reg;
    assign field_y   = out_fy_reg;
    assign potential = out_pot_reg;
    assign saturated = out_sat_reg;

endmodule
